/* sv/pssd_pkg.sv */
`default_nettype none

package pssd_pkg;

  // Sizes of the picture and palette.
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned MaxPixels      = 65536;

  localparam int unsigned PtrW   = 17;
  localparam int unsigned AreaW  = 17;
  localparam int unsigned WidthW = 9;
  localparam int unsigned HeightW = 8;

  localparam logic [PtrW-1:0] PtrSat = 17'h1FFFF;
  localparam logic [31:0]     WordOnes = 32'hFFFF_FFFF;

  localparam logic [WidthW-1:0]  DefWidth  = 9'd320;
  localparam logic [HeightW-1:0] DefHeight = 8'd200;
  localparam logic [AreaW-1:0]   DefArea   = 17'd64000;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;

  // Request action codes.
  localparam logic [1:0] ActBody    = 2'd0;
  localparam logic [1:0] ActPalette = 2'd1;
  localparam logic [1:0] ActNewPic  = 2'd2;

  // Commands passed from the front part to the back part.
  typedef enum logic [1:0] {
    CmdPixel   = 2'd0,
    CmdPalette = 2'd1,
    CmdDone    = 2'd2
  } cmd_op_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] body_byte;
    logic [7:0] palette_slot;
    logic [5:0] red_in;
    logic [5:0] green_in;
    logic [5:0] blue_in;
  } in_req_t;

  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        picture_done;
    logic        address_error;
  } out_req_t;

  typedef struct packed {
    cmd_op_e         op;
    logic [PtrW-1:0] addr;
    logic [7:0]      sel;
    logic [17:0]     rgb;
  } cmd_t;

  // Command pushed by the front part into the queue.
  typedef struct packed {
    logic push;
    cmd_t entry;
  } q_push_t;

endpackage

`default_nettype wire

/* sv/pssd_front.sv */
`default_nettype none

module pssd_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire pssd_pkg::in_req_t      in_req_i,
  input  wire logic                   kind_i,
  input  wire logic [8:0]             width_i,
  input  wire logic                   q_full_i,
  output pssd_pkg::q_push_t           q_push_o
);
  import pssd_pkg::*;

  logic [7:0]      hdr_q [15];
  logic [3:0]      cnt_q, cnt_d;
  logic            in_span_q, in_span_d;
  logic [31:0]     remain_q, remain_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            fin_q, fin_d;

  logic            accept;
  logic            hdr_wr;
  logic [PtrW-1:0] ptr_inc;
  logic [31:0]     x_w, y_w, off_w, len_w;
  logic signed [41:0] start_s;
  logic [PtrW-1:0] start_sat;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign ptr_inc = (ptr_q == PtrSat) ? ptr_q : ptr_q + 1'b1;

  assign x_w   = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign y_w   = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
  assign off_w = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
  assign len_w = {in_req_i.body_byte, hdr_q[14], hdr_q[13], hdr_q[12]};

  // Span start: signed row times width plus signed column, saturated.
  always_comb begin
    start_s = $signed(y_w) * $signed({1'b0, width_i}) + $signed(x_w);
    if (start_s < 0 || start_s >= 42'sd131071) begin
      start_sat = PtrSat;
    end else begin
      start_sat = start_s[PtrW-1:0];
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    in_span_d = in_span_q;
    remain_d  = remain_q;
    ptr_d     = ptr_q;
    fin_d     = fin_q;
    hdr_wr    = 1'b0;
    q_push_o.push       = 1'b0;
    q_push_o.entry.op   = CmdPixel;
    q_push_o.entry.addr = ptr_q;
    q_push_o.entry.sel  = in_req_i.body_byte;
    q_push_o.entry.rgb  = {in_req_i.red_in, in_req_i.green_in, in_req_i.blue_in};
    if (accept) begin
      case (in_req_i.action)
        ActPalette: begin
          q_push_o.push      = 1'b1;
          q_push_o.entry.op  = CmdPalette;
          q_push_o.entry.sel = in_req_i.palette_slot;
        end
        ActNewPic: begin
          cnt_d     = '0;
          in_span_d = 1'b0;
          remain_d  = '0;
          ptr_d     = '0;
          fin_d     = 1'b0;
        end
        ActBody: begin
          if (!fin_q) begin
            if (!kind_i) begin
              q_push_o.push = 1'b1;
              ptr_d         = ptr_inc;
            end else if (in_span_q) begin
              q_push_o.push = 1'b1;
              ptr_d         = ptr_inc;
              remain_d      = remain_q - 1'b1;
              if (remain_q == 32'd1) begin
                in_span_d = 1'b0;
              end
            end else begin
              hdr_wr = 1'b1;
              cnt_d  = cnt_q + 1'b1;
              if (cnt_q == 4'd15) begin
                if (off_w == WordOnes && len_w == WordOnes) begin
                  fin_d             = 1'b1;
                  q_push_o.push     = 1'b1;
                  q_push_o.entry.op = CmdDone;
                end else begin
                  ptr_d     = start_sat;
                  remain_d  = len_w;
                  in_span_d = (len_w != '0);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      in_span_q <= 1'b0;
      remain_q  <= '0;
      ptr_q     <= '0;
      fin_q     <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      in_span_q <= in_span_d;
      remain_q  <= remain_d;
      ptr_q     <= ptr_d;
      fin_q     <= fin_d;
    end
  end

  // Header bytes; the final byte is used straight from the request.
  always_ff @(posedge clk_i) begin
    if (hdr_wr && cnt_q != 4'd15) begin
      hdr_q[cnt_q] <= in_req_i.body_byte;
    end
  end

endmodule

`default_nettype wire

/* sv/pssd_queue.sv */
`default_nettype none

module pssd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pssd_pkg::q_push_t push_i,
  output logic                   full_o,
  output logic                   valid_o,
  output pssd_pkg::cmd_t         head_o,
  input  wire logic              pop_i
);
  import pssd_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  cmd_t            slot_q [QueueDepth];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i.push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      slot_q[wr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

/* sv/pssd_back.sv */
`default_nettype none

module pssd_back #(
  parameter int unsigned PALETTE_ENTRIES = pssd_pkg::PaletteEntries
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [8:0]     width_i,
  input  wire logic [7:0]     height_i,
  input  wire logic           q_valid_i,
  input  wire pssd_pkg::cmd_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pssd_pkg::out_req_t  out_req_o
);
  import pssd_pkg::*;

  localparam int unsigned IdxW = $clog2(PALETTE_ENTRIES);

  logic [17:0]      pal_q [PALETTE_ENTRIES];
  logic [17:0]      rd_q;
  logic [AreaW-1:0] area_q;
  logic             s1_valid_q, s1_done_q, s1_hit_q, s1_err_q;
  logic [15:0]      s1_addr_q;
  logic             adv;
  logic             in_range;
  logic             addr_err;

  assign adv      = !s1_valid_q || out_ready_i;
  assign q_pop_o  = q_valid_i && adv;
  assign in_range = ({1'b0, q_head_i.sel} < 9'(PALETTE_ENTRIES));
  assign addr_err = (q_head_i.addr >= area_q) ||
                    ({1'b0, q_head_i.addr} >= 18'(MaxPixels));

  // Picture area is a registered copy of the product of the size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= DefArea;
    end else begin
      area_q <= AreaW'(width_i * height_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= q_valid_i && (q_head_i.op != CmdPalette);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_done_q <= (q_head_i.op == CmdDone);
      s1_hit_q  <= in_range;
      s1_err_q  <= addr_err;
      s1_addr_q <= q_head_i.addr[15:0];
    end
  end

  // Palette memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_head_i.op == CmdPalette && in_range) begin
      pal_q[q_head_i.sel[IdxW-1:0]] <= q_head_i.rgb;
    end
    if (q_pop_o && q_head_i.op == CmdPixel) begin
      rd_q <= pal_q[q_head_i.sel[IdxW-1:0]];
    end
  end

  always_comb begin
    out_valid_o = s1_valid_q;
    out_req_o   = '0;
    if (s1_done_q) begin
      out_req_o.picture_done = 1'b1;
    end else begin
      out_req_o.pixel_address = s1_addr_q;
      out_req_o.alpha_out     = 8'hFF;
      out_req_o.address_error = s1_err_q;
      if (s1_hit_q) begin
        out_req_o.red_out   = {rd_q[17:12], 2'b00};
        out_req_o.green_out = {rd_q[11:6], 2'b00};
        out_req_o.blue_out  = {rd_q[5:0], 2'b00};
      end
    end
  end

endmodule

`default_nettype wire

/* sv/palette_sprite_segment_decoder.sv */
`default_nettype none

// Channel     | Direction | Handshake              | Payload
// ------------+-----------+------------------------+----------------------------
// input       | in        | in_valid_i / in_ready_o | in_req_i  (pssd_pkg::in_req_t)
// output      | out       | out_valid_o / out_ready_i | out_req_o (pssd_pkg::out_req_t)
// config      | in/out    | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One request is taken per cycle while the four-entry command queue has room;
// a pixel passes through a queue slot and then the output register before it leaves.
// The front part keeps the header, span and pointer state and resolves each
// request in the cycle it is taken; the back part reads the palette and
// holds the result in an output register.
// Reset clears all control state and sets the size registers to 320 by 200;
// the palette itself is not cleared.
// A stalled output only holds the back part; the queue absorbs requests
// until it fills, after which in_ready_o drops.

module palette_sprite_segment_decoder #(
  parameter int unsigned PALETTE_ENTRIES = pssd_pkg::PaletteEntries
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pssd_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pssd_pkg::out_req_t      out_req_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pssd_pkg::*;

  // Register indexes, taken from address bits three and two.
  localparam logic [1:0] RegKind   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  logic               kind_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic               cfg_wr;

  q_push_t q_push;
  logic    q_full, q_valid, q_pop;
  cmd_t    q_head;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= 1'b0;
      width_q  <= DefWidth;
      height_q <= DefHeight;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegKind:   kind_q   <= pwdata[0];
        RegWidth:  width_q  <= pwdata[WidthW-1:0];
        RegHeight: height_q <= pwdata[HeightW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegKind:   prdata = {31'd0, kind_q};
      RegWidth:  prdata = {23'd0, width_q};
      RegHeight: prdata = {24'd0, height_q};
      default:   prdata = '0;
    endcase
  end

  // Front part: takes requests and turns them into commands.
  pssd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .kind_i     (kind_q),
    .width_i    (width_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push)
  );

  // Command queue decoupling the two parts.
  pssd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  // Back part: palette memory, bounds check and output register.
  pssd_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  import pssd_pkg::*;

  // The action code that the block must ignore has no name in the package.
  localparam logic [1:0] ActIgnored = 2'd3;

  // Byte addresses of the configuration registers.
  localparam logic [3:0] RegKind   = 4'd0;
  localparam logic [3:0] RegWidth  = 4'd4;
  localparam logic [3:0] RegHeight = 4'd8;

  // Picture kinds as held in the kind register.
  localparam logic KindRaw    = 1'b0;
  localparam logic KindSprite = 1'b1;

  // Cycles allowed for the command queue to empty once no pixel is owed.
  localparam int unsigned TailCycles = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_req_t    out_req;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Idle rates of the two sides, in cycles out of a hundred.
  int unsigned send_idle = 14;
  int unsigned recv_idle = 61;
  // Cycles for which the receiver is to refuse every result.
  int unsigned hold_cycles = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;

  // Our own copy of the decoder: configuration, palette and span state.
  logic              cfg_kind = KindRaw;
  logic [WidthW-1:0] cfg_width = DefWidth;
  logic [HeightW-1:0] cfg_height = DefHeight;
  logic [17:0]       color_table [PaletteEntries];
  logic [127:0]      hdr = '0;
  int                hdr_count = 0;
  bit                in_span = 1'b0;
  logic [31:0]       span_left = '0;
  logic [PtrW-1:0]   wptr = '0;
  bit                pic_finished = 1'b0;
  // Pixel writes (and end-of-picture marks) still owed by the block, oldest first.
  out_req_t          pixels_due [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  palette_sprite_segment_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Works out what one accepted request does to the decoder and queues any
  // pixel it produces. Returns zero when the block simply ignores the request,
  // so that such requests are not counted as stimulus.
  function automatic bit decode_step(in_req_t r);
    out_req_t    px;
    logic [17:0] colour;
    logic [31:0] area;
    longint      start;
    if (r.action == ActPalette) begin
      color_table[r.palette_slot] = {r.red_in, r.green_in, r.blue_in};
      return 1'b1;
    end
    if (r.action == ActNewPic) begin
      // A new picture keeps the palette but forgets everything else.
      hdr = '0;
      hdr_count = 0;
      in_span = 1'b0;
      span_left = '0;
      wptr = '0;
      pic_finished = 1'b0;
      return 1'b1;
    end
    if (r.action == ActIgnored || pic_finished) return 1'b0;

    if (cfg_kind == KindRaw || in_span) begin
      // A pixel byte: look the index up and write at the current pointer.
      colour = color_table[r.body_byte];
      area = 32'(cfg_width) * 32'(cfg_height);
      px.pixel_address = wptr[15:0];
      px.red_out = {colour[17:12], 2'b00};
      px.green_out = {colour[11:6], 2'b00};
      px.blue_out = {colour[5:0], 2'b00};
      px.alpha_out = 8'hFF;
      px.picture_done = 1'b0;
      px.address_error = (32'(wptr) >= area) || (32'(wptr) >= MaxPixels);
      pixels_due.push_back(px);
      // The pointer sticks once it has saturated.
      if (wptr != PtrSat) wptr++;
      if (cfg_kind == KindSprite) begin
        span_left--;
        if (span_left == 0) in_span = 1'b0;
      end
      return 1'b1;
    end

    // Otherwise the byte belongs to a 16-byte little-endian span header.
    if (hdr_count == 0) hdr = '0;
    hdr[hdr_count*8 +: 8] = r.body_byte;
    hdr_count = (hdr_count + 1) % 16;
    if (hdr_count != 0) return 1'b1;

    if (hdr[95:64] == WordOnes && hdr[127:96] == WordOnes) begin
      // The terminating header: one end mark, and nothing more until a new picture.
      px = '0;
      px.picture_done = 1'b1;
      pixels_due.push_back(px);
      pic_finished = 1'b1;
      return 1'b1;
    end
    // Start is y*width+x with x and y taken as signed words; anything negative
    // or beyond the pointer range parks the pointer at saturation.
    start = longint'(signed'(hdr[63:32])) * longint'(cfg_width)
          + longint'(signed'(hdr[31:0]));
    wptr = (start < 0 || start >= longint'(PtrSat)) ? PtrSat : start[PtrW-1:0];
    span_left = hdr[127:96];
    in_span = (span_left != 0);
    return 1'b1;
  endfunction

  function automatic in_req_t body_req(logic [7:0] b);
    in_req_t r;
    // The palette fields are don't-care for a body byte, so they are scrambled.
    r.action = ActBody;
    r.body_byte = b;
    r.palette_slot = 8'($urandom);
    r.red_in = 6'($urandom);
    r.green_in = 6'($urandom);
    r.blue_in = 6'($urandom);
    return r;
  endfunction

  function automatic in_req_t palette_req(logic [7:0] slot, logic [5:0] red,
                                          logic [5:0] green, logic [5:0] blue);
    in_req_t r;
    r.action = ActPalette;
    r.body_byte = 8'($urandom);
    r.palette_slot = slot;
    r.red_in = red;
    r.green_in = green;
    r.blue_in = blue;
    return r;
  endfunction

  function automatic in_req_t ctrl_req(logic [1:0] action);
    in_req_t r;
    r = body_req(8'($urandom));
    r.action = action;
    return r;
  endfunction

  function automatic logic [31:0] pick_size(int unsigned max_size);
    case ($urandom_range(3))
      0: return 32'd1;
      1: return max_size;
      default: return $urandom_range(max_size, 1);
    endcase
  endfunction

  // Offers one request, with random idle cycles ahead of it, and holds it
  // until the block takes it. Valid is left high; whoever sends next or
  // wait_idle decides what happens on the following falling edge.
  task automatic send_req(in_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (!in_ready);
    if (decode_step(r)) items_taken++;
  endtask

  task automatic send_body(logic [7:0] b);
    send_req(body_req(b));
  endtask

  task automatic send_header(logic [31:0] x, logic [31:0] y, logic [31:0] off,
                             logic [31:0] len);
    logic [127:0] bytes;
    bytes = {len, off, y, x};
    for (int i = 0; i < 16; i++) begin
      send_body(bytes[i*8 +: 8]);
    end
  endtask

  // Stops offering requests, waits for every owed result and then lets the
  // command queue run dry, so that the registers may be rewritten safely.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // A setup and an access cycle to write, then the same to read the register
  // back and compare it with what it should now hold.
  task automatic write_register(logic [3:0] addr, logic [31:0] value);
    logic [31:0] stored;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (addr)
      RegKind: cfg_kind = value[0];
      RegWidth: cfg_width = value[WidthW-1:0];
      RegHeight: cfg_height = value[HeightW-1:0];
      default: ;
    endcase
    stored = (addr == RegKind) ? 32'(cfg_kind)
           : (addr == RegWidth) ? 32'(cfg_width) : 32'(cfg_height);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      $display("%0t: register %0h read back, expected %0h, actual %0h",
               $time, addr, stored, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic kind, logic [31:0] width, logic [31:0] height);
    wait_idle();
    write_register(RegKind, 32'(kind));
    write_register(RegWidth, width);
    write_register(RegHeight, height);
  endtask

  // Every palette entry is written before any pixel is decoded, so no pixel
  // can ever read an entry that holds nothing yet. The end entries take the
  // extreme colours.
  task automatic test_palette_fill();
    for (int i = 0; i < PaletteEntries; i++) begin
      if (i == 0) send_req(palette_req(8'(i), 6'd0, 6'd0, 6'd0));
      else if (i == PaletteEntries - 1) send_req(palette_req(8'(i), 6'd63, 6'd63, 6'd63));
      else send_req(palette_req(8'(i), 6'($urandom), 6'($urandom), 6'($urandom)));
    end
  endtask

  // Raw pictures: extreme indices, an ignored action, a palette rewrite that
  // the very next pixel must see, and running off the end of a 1x1 picture.
  task automatic test_raw_mode();
    configure(KindRaw, DefWidth, DefHeight);
    send_req(ctrl_req(ActNewPic));
    send_body(8'h00);
    send_body(8'hFF);
    send_body(8'hAA);
    send_body(8'h55);
    send_req(ctrl_req(ActIgnored));
    send_req(palette_req(8'h5A, 6'd63, 6'd0, 6'd42));
    send_body(8'h5A);
    configure(KindRaw, 32'd1, 32'd1);
    send_req(ctrl_req(ActNewPic));
    repeat (3) send_body(8'($urandom));
  endtask

  // Sprite pictures at full size: a plain span, an empty span straight into
  // the next header, the last pixel of the picture and the one past it, a
  // start beyond the pixel store, an all-ones offset that is not the end, a
  // start past the pointer range, a negative start, and finally the end
  // header with a trailing byte that must be dropped.
  task automatic test_sprite_mode();
    configure(KindSprite, DefWidth, DefHeight);
    send_req(ctrl_req(ActNewPic));
    send_header(32'd3, 32'd1, 32'd0, 32'd2);
    repeat (2) send_body(8'($urandom));
    send_header(32'd0, 32'd0, 32'd0, 32'd0);
    send_header(32'd319, 32'd199, 32'd0, 32'd2);
    repeat (2) send_body(8'($urandom));
    send_header(32'd0, 32'd250, WordOnes, 32'd1);
    send_body(8'($urandom));
    send_header(32'd0, 32'd410, 32'd0, 32'd1);
    send_body(8'($urandom));
    send_header(WordOnes, 32'd0, 32'd0, 32'd2);
    repeat (2) send_body(8'($urandom));
    send_header(32'd0, 32'd0, WordOnes, WordOnes);
    send_body(8'($urandom));
    send_req(ctrl_req(ActNewPic));
  endtask

  // The receiver refuses everything for a long stretch while the sender keeps
  // offering pixel bytes, so the queue fills and the input must stall.
  task automatic test_pressure();
    configure(KindRaw, DefWidth, DefHeight);
    send_idle = 0;
    recv_idle = 0;
    send_req(ctrl_req(ActNewPic));
    hold_cycles = 100;
    repeat (40) send_body(8'($urandom));
  endtask

  // One random setting of the registers followed by a run of requests. Sprite
  // runs are mostly well-formed spans with random content; the rest are end
  // headers, headers cut short, and stray requests, each followed by a new
  // picture so that the header alignment is recovered.
  task automatic random_segment(int unsigned quota);
    int unsigned goal;
    int unsigned choice;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] len;
    configure(1'($urandom_range(1)), pick_size(DefWidth), pick_size(DefHeight));
    send_req(ctrl_req(ActNewPic));
    goal = items_taken + quota;
    while (items_taken < goal) begin
      choice = $urandom_range(99);
      if (cfg_kind == KindRaw) begin
        if (choice < 85) send_body(8'($urandom));
        else if (choice < 92) send_req(palette_req(8'($urandom), 6'($urandom),
                                                   6'($urandom), 6'($urandom)));
        else if (choice < 96) send_req(ctrl_req(ActIgnored));
        else send_req(ctrl_req(ActNewPic));
      end else if (choice < 70) begin
        x = ($urandom_range(4) == 0) ? $urandom : $urandom_range(cfg_width - 1);
        y = $urandom_range(cfg_height);
        len = $urandom_range(12);
        send_header(x, y, $urandom, len);
        repeat (len) begin
          if ($urandom_range(19) == 0) begin
            send_req(palette_req(8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom)));
          end
          send_body(8'($urandom));
        end
      end else if (choice < 78) begin
        send_header($urandom, $urandom, WordOnes, WordOnes);
        repeat ($urandom_range(2)) send_body(8'($urandom));
        send_req(ctrl_req(ActNewPic));
      end else if (choice < 90) begin
        repeat ($urandom_range(15, 1)) send_body(8'($urandom));
        send_req(ctrl_req(ActNewPic));
      end else begin
        case ($urandom_range(2))
          0: send_req(palette_req(8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom)));
          1: send_req(ctrl_req(ActIgnored));
          default: send_body(8'($urandom));
        endcase
        send_req(ctrl_req(ActNewPic));
      end
    end
  endtask

  // Three rounds of random segments: a slow receiver, then a slow sender,
  // then both at full rate.
  task automatic test_random();
    send_idle = 14;
    recv_idle = 61;
    repeat (5) random_segment(38);
    send_idle = 61;
    recv_idle = 14;
    repeat (5) random_segment(38);
    send_idle = 0;
    recv_idle = 0;
    repeat (5) random_segment(38);
  endtask

  // The receiver decides its ready on each falling edge: refused outright
  // while a hold-off is running, otherwise at the current idle rate.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Each result taken at a rising edge is matched against the oldest owed one.
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: result with nothing owed, expected none, actual %h", $time, out_req);
        fail_count++;
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_address", 32'(want.pixel_address), 32'(out_req.pixel_address));
        check_field("red_out", 32'(want.red_out), 32'(out_req.red_out));
        check_field("green_out", 32'(want.green_out), 32'(out_req.green_out));
        check_field("blue_out", 32'(want.blue_out), 32'(out_req.blue_out));
        check_field("alpha_out", 32'(want.alpha_out), 32'(out_req.alpha_out));
        check_field("picture_done", 32'(want.picture_done), 32'(out_req.picture_done));
        check_field("address_error", 32'(want.address_error), 32'(out_req.address_error));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_palette_fill();
    test_raw_mode();
    test_sprite_mode();
    test_pressure();
    test_random();
    wait_idle();
    if (fail_count == 0 && pixels_due.size() == 0) begin
      $display("palette_sprite_segment_decoder regression: pass");
    end else begin
      $display("palette_sprite_segment_decoder regression: fail");
    end
    $finish;
  end

  // A hang anywhere ends the run here.
  initial begin
    #5000000;
    $display("palette_sprite_segment_decoder regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

/* palette_sprite_segment_decoder.f */
sv/pssd_pkg.sv
sv/pssd_front.sv
sv/pssd_queue.sv
sv/pssd_back.sv
sv/palette_sprite_segment_decoder.sv
tb/tb_top.sv
